FILE: hw/rtl/status_led_pattern_sequencer_unit_macros.svh
// Assertion macros shared by the status LED sequencer RTL.
`ifndef STATUS_LED_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define STATUS_LED_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define SLPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("status LED sequencer check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SLPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("status LED sequencer check failed");

`endif

FILE: hw/rtl/slps_pkg.sv
// Types and constants of the status LED pattern sequencer.
`default_nettype none

package slps_pkg;

    typedef struct packed {
        logic [6:0] battery_pct;
        logic       imu_ready;
        logic       standby;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] status_level;
        logic       battery_led;
    } out_beat_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_STATUS_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RISE_STEP_MS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FALL_STEP_MS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BREATH_PEAK      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAUSE_MS         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_BATTERY_PCT  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_BATTERY_PCT = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_HALF_MS    = 3'd7;

    // Register reset values.
    localparam logic        RST_STATUS_ENABLE    = 1'b1;
    localparam logic [7:0]  RST_RISE_STEP_MS     = 8'd5;
    localparam logic [7:0]  RST_FALL_STEP_MS     = 8'd15;
    localparam logic [7:0]  RST_BREATH_PEAK      = 8'd80;
    localparam logic [15:0] RST_PAUSE_MS         = 16'd2000;
    localparam logic [6:0]  RST_LOW_BATTERY_PCT  = 7'd15;
    localparam logic [6:0]  RST_FULL_BATTERY_PCT = 7'd99;
    localparam logic [15:0] RST_BLINK_HALF_MS    = 16'd300;

    // Fixed levels and flash timing (reload values are period minus one).
    localparam logic [7:0]  IMU_WAIT_LEVEL   = 8'd128;
    localparam logic [7:0]  FLASH_LEVEL      = 8'd255;
    localparam logic [7:0]  MAX_LEVEL        = 8'd255;
    localparam logic [15:0] POLL_RELOAD      = 16'd99;
    localparam logic [15:0] FLASH_ON_RELOAD  = 16'd49;
    localparam logic [15:0] FLASH_GAP_RELOAD = 16'd69;

    typedef enum logic [4:0] {
        FLASH_IDLE = 5'b00001,
        FLASH_POLL = 5'b00010,
        FLASH_ON1  = 5'b00100,
        FLASH_GAP  = 5'b01000,
        FLASH_ON2  = 5'b10000
    } flash_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/status_led_pattern_sequencer_unit.sv
// Status LED pattern sequencer: battery blink, breathing and double-flash patterns.
// A result beat appears on m_* in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle; the whole state update fits between the
// state registers and the result register, and s_ready stays high while the result
// register is empty or being drained.
// Reset: synchronous, active low; clears all pattern state and loads register defaults.
`default_nettype none

`include "status_led_pattern_sequencer_unit_macros.svh"

module status_led_pattern_sequencer_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [slps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [slps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire slps_pkg::in_beat_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output slps_pkg::out_beat_t                      m_data
);

    // Configuration registers.
    logic        status_enable_reg;
    logic [7:0]  rise_step_ms_reg;
    logic [7:0]  fall_step_ms_reg;
    logic [7:0]  breath_peak_reg;
    logic [15:0] pause_ms_reg;
    logic [6:0]  low_battery_pct_reg;
    logic [6:0]  full_battery_pct_reg;
    logic [15:0] blink_half_ms_reg;

    // Pattern state.
    logic [7:0]             breath_level_reg, breath_level_next;
    logic                   breath_rising_reg, breath_rising_next;
    logic [15:0]            step_timer_reg, step_timer_next;
    logic [15:0]            pause_timer_reg, pause_timer_next;
    slps_pkg::flash_state_t flash_state_reg, flash_state_next;
    logic [15:0]            blink_timer_reg, blink_timer_next;
    logic                   battery_level_reg, battery_level_next;
    logic [7:0]             shown_level_reg, shown_level_next;

    logic                   m_valid_reg;
    slps_pkg::out_beat_t    m_data_reg;

    logic        accept;
    logic        paused;
    logic [7:0]  level_step;
    logic [15:0] rise_reload;
    logic [15:0] fall_reload;
    logic [15:0] blink_reload;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign paused       = (pause_timer_reg != 16'd0);
    assign rise_reload  = (rise_step_ms_reg == 8'd0) ? 16'd0
                        : {8'd0, rise_step_ms_reg - 8'd1};
    assign fall_reload  = (fall_step_ms_reg == 8'd0) ? 16'd0
                        : {8'd0, fall_step_ms_reg - 8'd1};
    assign blink_reload = (blink_half_ms_reg == 16'd0) ? 16'd0
                        : blink_half_ms_reg - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_enable_reg    <= slps_pkg::RST_STATUS_ENABLE;
            rise_step_ms_reg     <= slps_pkg::RST_RISE_STEP_MS;
            fall_step_ms_reg     <= slps_pkg::RST_FALL_STEP_MS;
            breath_peak_reg      <= slps_pkg::RST_BREATH_PEAK;
            pause_ms_reg         <= slps_pkg::RST_PAUSE_MS;
            low_battery_pct_reg  <= slps_pkg::RST_LOW_BATTERY_PCT;
            full_battery_pct_reg <= slps_pkg::RST_FULL_BATTERY_PCT;
            blink_half_ms_reg    <= slps_pkg::RST_BLINK_HALF_MS;
        end else if (cfg_we) begin
            case (cfg_index)
                slps_pkg::REG_STATUS_ENABLE:    status_enable_reg    <= cfg_wdata[0];
                slps_pkg::REG_RISE_STEP_MS:     rise_step_ms_reg     <= cfg_wdata[7:0];
                slps_pkg::REG_FALL_STEP_MS:     fall_step_ms_reg     <= cfg_wdata[7:0];
                slps_pkg::REG_BREATH_PEAK:      breath_peak_reg      <= cfg_wdata[7:0];
                slps_pkg::REG_PAUSE_MS:         pause_ms_reg         <= cfg_wdata;
                slps_pkg::REG_LOW_BATTERY_PCT:  low_battery_pct_reg  <= cfg_wdata[6:0];
                slps_pkg::REG_FULL_BATTERY_PCT: full_battery_pct_reg <= cfg_wdata[6:0];
                slps_pkg::REG_BLINK_HALF_MS:    blink_half_ms_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        breath_level_next  = breath_level_reg;
        breath_rising_next = breath_rising_reg;
        step_timer_next    = step_timer_reg;
        pause_timer_next   = pause_timer_reg;
        flash_state_next   = flash_state_reg;
        blink_timer_next   = blink_timer_reg;
        battery_level_next = battery_level_reg;
        shown_level_next   = shown_level_reg;
        level_step         = breath_level_reg;

        if (paused) begin
            pause_timer_next = pause_timer_reg - 16'd1;
        end

        // The low band wins over the full band when the thresholds overlap.
        if (s_data.battery_pct < low_battery_pct_reg) begin
            if (blink_timer_reg == 16'd0) begin
                battery_level_next = !battery_level_reg;
                blink_timer_next   = blink_reload;
            end else begin
                blink_timer_next = blink_timer_reg - 16'd1;
            end
        end else if (s_data.battery_pct >= full_battery_pct_reg) begin
            battery_level_next = 1'b0;
        end else begin
            battery_level_next = 1'b1;
        end

        if (!s_data.imu_ready) begin
            flash_state_next = slps_pkg::FLASH_IDLE;
            shown_level_next = slps_pkg::IMU_WAIT_LEVEL;
        end else if (s_data.standby && status_enable_reg) begin
            flash_state_next = slps_pkg::FLASH_IDLE;
            if (!paused) begin
                if (step_timer_reg != 16'd0) begin
                    step_timer_next = step_timer_reg - 16'd1;
                end else begin
                    if (breath_rising_reg) begin
                        if (breath_level_reg == slps_pkg::MAX_LEVEL) begin
                            level_step         = slps_pkg::MAX_LEVEL;
                            breath_rising_next = 1'b0;
                        end else begin
                            level_step         = breath_level_reg + 8'd1;
                            breath_rising_next = !(level_step > breath_peak_reg);
                        end
                        step_timer_next = rise_reload;
                    end else begin
                        if (breath_level_reg == 8'd0) begin
                            level_step         = 8'd0;
                            breath_rising_next = 1'b1;
                        end else begin
                            level_step = breath_level_reg - 8'd1;
                            if (level_step == 8'd0) begin
                                breath_rising_next = 1'b1;
                            end
                        end
                        step_timer_next = fall_reload;
                    end
                    breath_level_next = level_step;
                    shown_level_next  = level_step;
                    // Reaching dark starts the pause and restarts the step count.
                    if (level_step == 8'd0) begin
                        pause_timer_next = pause_ms_reg;
                        step_timer_next  = 16'd0;
                    end
                end
            end
        end else if (status_enable_reg) begin
            if (flash_state_reg == slps_pkg::FLASH_IDLE) begin
                flash_state_next = slps_pkg::FLASH_POLL;
                step_timer_next  = slps_pkg::POLL_RELOAD;
            end else if (step_timer_reg != 16'd0) begin
                step_timer_next = step_timer_reg - 16'd1;
            end else begin
                case (flash_state_reg)
                    slps_pkg::FLASH_POLL: begin
                        if (paused) begin
                            step_timer_next = slps_pkg::POLL_RELOAD;
                        end else begin
                            shown_level_next = slps_pkg::FLASH_LEVEL;
                            flash_state_next = slps_pkg::FLASH_ON1;
                            step_timer_next  = slps_pkg::FLASH_ON_RELOAD;
                        end
                    end
                    slps_pkg::FLASH_ON1: begin
                        shown_level_next = 8'd0;
                        flash_state_next = slps_pkg::FLASH_GAP;
                        step_timer_next  = slps_pkg::FLASH_GAP_RELOAD;
                    end
                    slps_pkg::FLASH_GAP: begin
                        shown_level_next = slps_pkg::FLASH_LEVEL;
                        flash_state_next = slps_pkg::FLASH_ON2;
                        step_timer_next  = slps_pkg::FLASH_ON_RELOAD;
                    end
                    default: begin
                        shown_level_next = 8'd0;
                        pause_timer_next = pause_ms_reg;
                        flash_state_next = slps_pkg::FLASH_POLL;
                        step_timer_next  = slps_pkg::POLL_RELOAD;
                    end
                endcase
            end
        end else begin
            flash_state_next = slps_pkg::FLASH_IDLE;
            shown_level_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            breath_level_reg  <= 8'd0;
            breath_rising_reg <= 1'b1;
            step_timer_reg    <= 16'd0;
            pause_timer_reg   <= 16'd0;
            flash_state_reg   <= slps_pkg::FLASH_IDLE;
            blink_timer_reg   <= 16'd0;
            battery_level_reg <= 1'b0;
            shown_level_reg   <= 8'd0;
        end else if (accept) begin
            breath_level_reg  <= breath_level_next;
            breath_rising_reg <= breath_rising_next;
            step_timer_reg    <= step_timer_next;
            pause_timer_reg   <= pause_timer_next;
            flash_state_reg   <= flash_state_next;
            blink_timer_reg   <= blink_timer_next;
            battery_level_reg <= battery_level_next;
            shown_level_reg   <= shown_level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.status_level <= shown_level_next;
            m_data_reg.battery_led  <= battery_level_next;
        end
    end

    `SLPS_ASSERT_NEXT(a_accept_gives_result, accept, m_valid_reg)
    `SLPS_ASSERT_NEXT(a_imu_wait_level, accept && !s_data.imu_ready,
        m_data_reg.status_level == slps_pkg::IMU_WAIT_LEVEL)
    `SLPS_ASSERT_NEXT(a_full_battery_dark,
        accept && (s_data.battery_pct >= full_battery_pct_reg)
            && (s_data.battery_pct >= low_battery_pct_reg),
        !m_data_reg.battery_led)
    `SLPS_ASSERT_NEXT(a_pause_holds_breath,
        accept && paused && s_data.imu_ready && s_data.standby && status_enable_reg,
        $stable(breath_level_reg) && $stable(step_timer_reg))
    `SLPS_ASSERT_SAME(a_result_mirrors_state, m_valid_reg && !$past(cfg_we),
        (m_data_reg.status_level == shown_level_reg)
            && (m_data_reg.battery_led == battery_level_reg))

endmodule

`default_nettype wire

FILE: tb/tb_status_led_pattern_sequencer_unit.sv
// Self-checking testbench for the status LED pattern sequencer.
`default_nettype none

module tb_status_led_pattern_sequencer_unit;
    import slps_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_CYCLES = 400_000;

    typedef enum int {
        RUN_FLASH,
        RUN_BREATH,
        RUN_EITHER
    } tick_mode_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    in_beat_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_beat_t              m_data;

    status_led_pattern_sequencer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Register copies as the block should hold them.
    logic        cfg_en;
    logic [7:0]  cfg_rise;
    logic [7:0]  cfg_fall;
    logic [7:0]  cfg_peak;
    logic [15:0] cfg_pause;
    logic [6:0]  cfg_low;
    logic [6:0]  cfg_full;
    logic [15:0] cfg_blink;

    // Pattern state as the block should hold it.
    logic [7:0]   lvl;
    logic         rising;
    logic [15:0]  step_left;
    logic [15:0]  pause_left;
    flash_state_t phase;
    logic [15:0]  blink_left;
    logic         bat_lvl;
    logic [7:0]   shown;

    out_beat_t led_expect_q[$];
    int        mismatch_count;
    int        src_idle_pct;
    int        sink_idle_pct;
    int        hold_off_reqs;

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    initial begin
        #(WATCHDOG_CYCLES * 2 * CLK_HALF);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [15:0] period_reload(input logic [15:0] p);
        return (p == 16'd0) ? 16'd0 : p - 16'd1;
    endfunction

    // Advances the pattern state by one tick and returns the LED levels it shows.
    function automatic out_beat_t next_led_levels(input in_beat_t t);
        logic      held;
        out_beat_t r;
        held = (pause_left != 16'd0);
        if (held)
            pause_left = pause_left - 16'd1;

        if (t.battery_pct < cfg_low) begin
            if (blink_left == 16'd0) begin
                bat_lvl    = ~bat_lvl;
                blink_left = period_reload(cfg_blink);
            end else begin
                blink_left = blink_left - 16'd1;
            end
        end else if (t.battery_pct >= cfg_full) begin
            bat_lvl = 1'b0;
        end else begin
            bat_lvl = 1'b1;
        end

        if (!t.imu_ready) begin
            phase = FLASH_IDLE;
            shown = IMU_WAIT_LEVEL;
        end else if (t.standby && cfg_en) begin
            phase = FLASH_IDLE;
            if (!held) begin
                if (step_left != 16'd0) begin
                    step_left = step_left - 16'd1;
                end else begin
                    if (rising) begin
                        if (lvl == MAX_LEVEL) begin
                            rising = 1'b0;
                        end else begin
                            lvl = lvl + 8'd1;
                            if (lvl > cfg_peak)
                                rising = 1'b0;
                        end
                        step_left = period_reload({8'd0, cfg_rise});
                    end else begin
                        if (lvl != 8'd0)
                            lvl = lvl - 8'd1;
                        if (lvl == 8'd0)
                            rising = 1'b1;
                        step_left = period_reload({8'd0, cfg_fall});
                    end
                    shown = lvl;
                    // Reaching the bottom of a breath starts the dark pause.
                    if (lvl == 8'd0) begin
                        pause_left = cfg_pause;
                        step_left  = 16'd0;
                    end
                end
            end
        end else if (cfg_en) begin
            if (phase == FLASH_IDLE) begin
                phase     = FLASH_POLL;
                step_left = POLL_RELOAD;
            end else if (step_left != 16'd0) begin
                step_left = step_left - 16'd1;
            end else begin
                case (phase)
                    FLASH_POLL: begin
                        if (held) begin
                            step_left = POLL_RELOAD;
                        end else begin
                            shown     = FLASH_LEVEL;
                            phase     = FLASH_ON1;
                            step_left = FLASH_ON_RELOAD;
                        end
                    end
                    FLASH_ON1: begin
                        shown     = 8'd0;
                        phase     = FLASH_GAP;
                        step_left = FLASH_GAP_RELOAD;
                    end
                    FLASH_GAP: begin
                        shown     = FLASH_LEVEL;
                        phase     = FLASH_ON2;
                        step_left = FLASH_ON_RELOAD;
                    end
                    default: begin
                        shown      = 8'd0;
                        pause_left = cfg_pause;
                        phase      = FLASH_POLL;
                        step_left  = POLL_RELOAD;
                    end
                endcase
            end
        end else begin
            phase = FLASH_IDLE;
            shown = 8'd0;
        end

        r.status_level = shown;
        r.battery_led  = bat_lvl;
        return r;
    endfunction

    // Results are checked before the beat taken at the same edge is predicted.
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (led_expect_q.size() == 0) begin
                    $error("result beat with no tick pending: status_level %0d battery_led %0d",
                           m_data.status_level, m_data.battery_led);
                    mismatch_count++;
                end else begin
                    want = led_expect_q.pop_front();
                    if (m_data.status_level !== want.status_level) begin
                        $error("status_level: expected %0d, got %0d",
                               want.status_level, m_data.status_level);
                        mismatch_count++;
                    end
                    if (m_data.battery_led !== want.battery_led) begin
                        $error("battery_led: expected %0d, got %0d",
                               want.battery_led, m_data.battery_led);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                led_expect_q.push_back(next_led_levels(s_data));
        end
    end

    // Receiver side: random stalls, plus one long hold-off whenever one is requested.
    initial begin : sink_side
        int served;
        served  = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_reqs != served) begin
                served++;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_tick(input in_beat_t b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Waits on an edge first so that a beat taken at the current edge is already queued.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (led_expect_q.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_STATUS_ENABLE:    cfg_en    = val[0];
            REG_RISE_STEP_MS:     cfg_rise  = val[7:0];
            REG_FALL_STEP_MS:     cfg_fall  = val[7:0];
            REG_BREATH_PEAK:      cfg_peak  = val[7:0];
            REG_PAUSE_MS:         cfg_pause = val;
            REG_LOW_BATTERY_PCT:  cfg_low   = val[6:0];
            REG_FULL_BATTERY_PCT: cfg_full  = val[6:0];
            REG_BLINK_HALF_MS:    cfg_blink = val;
            default: ;
        endcase
    endtask

    // Lets the block drain, then rewrites every register.
    task automatic reprogram(input logic en, input logic [7:0] rise, input logic [7:0] fall,
                             input logic [7:0] peak, input logic [15:0] pause,
                             input logic [6:0] low, input logic [6:0] full,
                             input logic [15:0] blink);
        wait_quiet();
        write_reg(REG_STATUS_ENABLE, {15'd0, en});
        write_reg(REG_RISE_STEP_MS, {8'd0, rise});
        write_reg(REG_FALL_STEP_MS, {8'd0, fall});
        write_reg(REG_BREATH_PEAK, {8'd0, peak});
        write_reg(REG_PAUSE_MS, pause);
        write_reg(REG_LOW_BATTERY_PCT, {9'd0, low});
        write_reg(REG_FULL_BATTERY_PCT, {9'd0, full});
        write_reg(REG_BLINK_HALF_MS, blink);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Sends runs of well-formed ticks with a steady mode; some runs are random noise.
    task automatic run_ticks(input int count, input tick_mode_t mode, input int noise_pct);
        int       left;
        int       seg;
        int       i;
        bit       noisy;
        bit       sb;
        in_beat_t b;
        left = count;
        while (left > 0) begin
            seg = $urandom_range(150, 20);
            if (seg > left)
                seg = left;
            noisy = ($urandom_range(99) < noise_pct);
            sb    = (mode == RUN_EITHER) ? 1'($urandom_range(1)) : (mode == RUN_BREATH);
            for (i = 0; i < seg; i++) begin
                b.battery_pct = 7'($urandom_range(100));
                if (noisy) begin
                    b.imu_ready = 1'($urandom_range(1));
                    b.standby   = 1'($urandom_range(1));
                end else begin
                    b.imu_ready = 1'b1;
                    b.standby   = sb;
                end
                send_tick(b);
            end
            left -= seg;
        end
    endtask

    // Default registers: battery thresholds at their edges, sensor wait, first steps
    // of breathing and polling, and switches between the modes.
    task automatic test_directed_ticks();
        int unsigned pct_list [24] = '{0, 127, 100, 99, 98, 15, 14, 64, 63, 1, 50, 50,
                                       20, 20, 20, 30, 30, 30, 40, 0, 99, 14, 100, 2};
        bit [1:0]    flag_list [24] = '{2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b11,
                                        2'b11, 2'b11, 2'b11, 2'b11, 2'b10, 2'b10, 2'b11,
                                        2'b11, 2'b10, 2'b00, 2'b01, 2'b11, 2'b11, 2'b10,
                                        2'b10, 2'b01, 2'b11};
        in_beat_t    b;
        int          i;
        for (i = 0; i < 24; i++) begin
            b.battery_pct = 7'(pct_list[i]);
            {b.imu_ready, b.standby} = flag_list[i];
            send_tick(b);
        end
    endtask

    task automatic test_breathing();
        reprogram(1'b1, 8'd1, 8'd2, 8'd6, 16'd12, 7'd30, 7'd70, 16'd3);
        run_ticks(120, RUN_BREATH, 15);
        reprogram(1'b1, 8'd3, 8'd1, 8'd20, 16'd0, 7'd50, 7'd50, 16'd1);
        run_ticks(130, RUN_BREATH, 15);
    endtask

    // A pause longer than the poll makes a finished poll start over without flashing.
    task automatic test_double_flash();
        reprogram(1'b1, 8'd4, 8'd4, 8'd80, 16'd150, 7'd20, 7'd90, 16'd7);
        run_ticks(350, RUN_FLASH, 10);
        reprogram(1'b1, 8'd4, 8'd4, 8'd80, 16'd0, 7'd20, 7'd90, 16'd7);
        run_ticks(200, RUN_FLASH, 10);
    endtask

    task automatic test_register_extremes();
        // Zero periods act as one tick; a peak of 255 lets the level saturate.
        reprogram(1'b1, 8'd0, 8'd0, 8'd255, 16'd0, 7'd100, 7'd100, 16'd0);
        run_ticks(420, RUN_BREATH, 0);
        // Disabled patterns never load the pause, so the largest values are safe here.
        reprogram(1'b0, 8'd255, 8'd255, 8'd1, 16'hFFFF, 7'd0, 7'd0, 16'hFFFF);
        run_ticks(40, RUN_EITHER, 30);
        reprogram(1'b1, 8'd1, 8'd1, 8'd254, 16'd0, 7'd1, 7'd2, 16'd1);
        run_ticks(60, RUN_EITHER, 20);
    endtask

    task automatic test_output_hold_off();
        reprogram(1'b1, 8'd2, 8'd2, 8'd10, 16'd30, 7'd40, 7'd60, 16'd5);
        hold_off_reqs++;
        run_ticks(100, RUN_EITHER, 20);
    endtask

    task automatic test_random_settings();
        int k;
        for (k = 0; k < 3; k++) begin
            reprogram(($urandom_range(9) != 0), 8'($urandom_range(4)), 8'($urandom_range(4)),
                      ($urandom_range(3) == 0) ? 8'd254 : 8'($urandom_range(30, 1)),
                      16'($urandom_range(200)), 7'($urandom_range(100)),
                      7'($urandom_range(100)), 16'($urandom_range(20, 1)));
            run_ticks(60, RUN_EITHER, 25);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        mismatch_count = 0;
        hold_off_reqs  = 0;
        src_idle_pct   = 19;
        sink_idle_pct  = 65;

        cfg_en     = RST_STATUS_ENABLE;
        cfg_rise   = RST_RISE_STEP_MS;
        cfg_fall   = RST_FALL_STEP_MS;
        cfg_peak   = RST_BREATH_PEAK;
        cfg_pause  = RST_PAUSE_MS;
        cfg_low    = RST_LOW_BATTERY_PCT;
        cfg_full   = RST_FULL_BATTERY_PCT;
        cfg_blink  = RST_BLINK_HALF_MS;
        lvl        = 8'd0;
        rising     = 1'b1;
        step_left  = 16'd0;
        pause_left = 16'd0;
        phase      = FLASH_IDLE;
        blink_left = 16'd0;
        bat_lvl    = 1'b0;
        shown      = 8'd0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ticks();
        test_breathing();
        src_idle_pct  = 65;
        sink_idle_pct = 19;
        test_double_flash();
        test_register_extremes();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_output_hold_off();
        test_random_settings();

        wait_quiet();
        if (mismatch_count == 0 && led_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
